>>> hdl/dcr_pkg.sv
package dcr_pkg;

    localparam int DEPTH    = 512;
    localparam int IDX_W    = $clog2(DEPTH);
    localparam int CNT_W    = $clog2(DEPTH + 1);
    localparam int SMP_W    = 16;
    localparam int OUT_W    = 17;
    // exact window sum: DEPTH samples of SMP_W bits, signed
    localparam int SUM_W    = SMP_W + IDX_W;
    localparam int DIVCNT_W = $clog2(SUM_W + 1);

    typedef logic signed [SMP_W-1:0] sample_t;
    typedef logic signed [OUT_W-1:0] result_t;
    typedef logic signed [SUM_W-1:0] sum_t;
    typedef logic [SUM_W-1:0]        mag_t;
    typedef logic [CNT_W-1:0]        divisor_t;
    typedef logic [IDX_W-1:0]        index_t;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_READ = 4'b0010,
        ST_DIV  = 4'b0100,
        ST_DONE = 4'b1000
    } state_t;

    typedef struct packed {
        logic start;
        logic done;
    } div_ctrl_t;

endpackage

>>> hdl/dcr_ifs.sv
interface dcr_sample_if;
    import dcr_pkg::*;

    logic    valid;
    logic    ready;
    sample_t sample_in;

    modport source (output valid, output sample_in, input ready);
    modport sink   (input valid, input sample_in, output ready);
endinterface

interface dcr_result_if;
    import dcr_pkg::*;

    logic    valid;
    logic    ready;
    result_t dc_removed;

    modport source (output valid, output dc_removed, input ready);
    modport sink   (input valid, input dc_removed, output ready);
endinterface

>>> hdl/dcr_ram.sv
module dcr_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 512
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> hdl/dcr_div.sv
// Restoring divider, one quotient bit per cycle, MSB first.
module dcr_div (
    input  logic                clk,
    input  logic                rst_n,
    input  dcr_pkg::div_ctrl_t  ctrl_in,
    output dcr_pkg::div_ctrl_t  ctrl_out,
    input  dcr_pkg::mag_t       dividend,
    input  dcr_pkg::divisor_t   divisor,
    output dcr_pkg::mag_t       quotient
);
    import dcr_pkg::*;

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [DIVCNT_W-1:0] cnt_reg, cnt_next;
    mag_t                q_reg, q_next;
    divisor_t            rem_reg, rem_next;
    divisor_t            dvs_reg, dvs_next;
    logic [CNT_W:0]      rem_sh;
    logic [CNT_W:0]      rem_sub;
    logic                ge;

    always_comb
    begin
        rem_sh  = {rem_reg, q_reg[SUM_W-1]};
        rem_sub = rem_sh - {1'b0, dvs_reg};
        ge      = (rem_sh >= {1'b0, dvs_reg});

        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        q_next    = q_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;

        if (ctrl_in.start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            q_next    = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            q_next   = {q_reg[SUM_W-2:0], ge};
            rem_next = ge ? rem_sub[CNT_W-1:0] : rem_sh[CNT_W-1:0];
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == DIVCNT_W'(SUM_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg   <= q_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign quotient       = q_reg;
    assign ctrl_out.start = 1'b0;
    assign ctrl_out.done  = done_reg;

endmodule

>>> hdl/moving_average_dc_remover.sv
// Moving-average DC remover. Each request carries one signed 16-bit sample; the block
// stores it in a ring of the last DEPTH samples (one synchronous RAM), updates the exact
// window sum and returns the sample minus the window mean, truncated toward zero. During
// warm-up the mean divides by the number of samples seen, unless simplified_mode is set.
// The result passes through one RAM read, one bit-serial divide step per sum bit, the
// divider's done flag, and the final subtract into the output register. A new request is
// taken only once the result is in the output register. The result sits in an output
// register, so the next request is taken while it waits; if it is still waiting when the
// next divide ends, the input stalls until it is taken. The ring needs no clearing pass
// after reset: entries are treated as zero until the ring has wrapped once.
module moving_average_dc_remover (
    input  logic               clk,
    input  logic               rst_n,
    dcr_sample_if.sink         sample_ch,
    dcr_result_if.source       result_ch,
    input  logic               cfg_we,
    input  logic               cfg_wdata
);
    import dcr_pkg::*;

    state_t    state_reg, state_next;
    index_t    idx_reg, idx_next;
    logic      filled_reg, filled_next;
    logic      mode_reg, mode_next;
    sum_t      sum_reg, sum_next;
    sample_t   smp_reg, smp_next;
    logic      first_reg, first_next;
    divisor_t  dvs_reg, dvs_next;
    logic      neg_reg, neg_next;
    logic      oval_reg, oval_next;
    result_t   odata_reg, odata_next;

    index_t    idx_step;
    logic      filled_step;
    sample_t   ram_rdata;
    sample_t   old_smp;
    sum_t      sum_new;
    mag_t      sum_mag;
    mag_t      quotient;
    logic signed [SUM_W:0] mean;
    logic signed [SUM_W:0] diff;
    div_ctrl_t div_req, div_rsp;
    logic      accept;
    logic      out_free;

    assign accept   = sample_ch.valid && (state_reg == ST_IDLE);
    assign out_free = !oval_reg || result_ch.ready;

    always_comb
    begin
        idx_step    = (idx_reg == index_t'(DEPTH - 1)) ? '0 : idx_reg + 1'b1;
        filled_step = filled_reg || (idx_step == index_t'(DEPTH - 1));

        // entries not yet written during the first pass read as zero
        old_smp = first_reg ? '0 : ram_rdata;
        sum_new = sum_reg - SUM_W'(old_smp) + SUM_W'(smp_reg);
        sum_mag = sum_new[SUM_W-1] ? mag_t'(-sum_new) : mag_t'(sum_new);

        mean = neg_reg ? -$signed({1'b0, quotient}) : $signed({1'b0, quotient});
        diff = (SUM_W+1)'(smp_reg) - mean;

        state_next  = state_reg;
        idx_next    = idx_reg;
        filled_next = filled_reg;
        mode_next   = cfg_we ? cfg_wdata : mode_reg;
        sum_next    = sum_reg;
        smp_next    = smp_reg;
        first_next  = first_reg;
        dvs_next    = dvs_reg;
        neg_next    = neg_reg;
        oval_next   = (oval_reg && result_ch.ready) ? 1'b0 : oval_reg;
        odata_next  = odata_reg;
        div_req     = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (sample_ch.valid)
                begin
                    idx_next    = idx_step;
                    filled_next = filled_step;
                    first_next  = !filled_reg;
                    smp_next    = sample_ch.sample_in;
                    dvs_next    = (mode_reg || filled_step) ? CNT_W'(DEPTH)
                                                            : CNT_W'(idx_step) + 1'b1;
                    state_next  = ST_READ;
                end
            end
            ST_READ:
            begin
                sum_next      = sum_new;
                neg_next      = sum_new[SUM_W-1];
                div_req.start = 1'b1;
                state_next    = ST_DIV;
            end
            ST_DIV:
            begin
                if (div_rsp.done)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    oval_next  = 1'b1;
                    odata_next = diff[OUT_W-1:0];
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    dcr_ram #(
        .WIDTH (SMP_W),
        .DEPTH (DEPTH)
    ) u_ring (
        .clk   (clk),
        .we    (state_reg == ST_READ),
        .waddr (idx_reg),
        .wdata (smp_reg),
        .re    (accept),
        .raddr (idx_step),
        .rdata (ram_rdata)
    );

    dcr_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl_in  (div_req),
        .ctrl_out (div_rsp),
        .dividend (sum_mag),
        .divisor  (dvs_reg),
        .quotient (quotient)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            idx_reg    <= index_t'(DEPTH - 1);
            filled_reg <= 1'b0;
            mode_reg   <= 1'b0;
            sum_reg    <= '0;
            oval_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            idx_reg    <= idx_next;
            filled_reg <= filled_next;
            mode_reg   <= mode_next;
            sum_reg    <= sum_next;
            oval_reg   <= oval_next;
        end
    end

    always_ff @(posedge clk)
    begin
        smp_reg   <= smp_next;
        first_reg <= first_next;
        dvs_reg   <= dvs_next;
        neg_reg   <= neg_next;
        odata_reg <= odata_next;
    end

    assign sample_ch.ready      = (state_reg == ST_IDLE);
    assign result_ch.valid      = oval_reg;
    assign result_ch.dc_removed = odata_reg;

endmodule

>>> bench/moving_average_dc_remover_tb.sv
`timescale 1ns / 1ps

module moving_average_dc_remover_tb;
    import dcr_pkg::*;

    localparam int LONG_HOLD    = 300;
    localparam int TAIL_CYCLES  = 40;
    localparam int MAX_GAP      = 4;
    localparam int CORNER_N     = 20;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    logic cfg_wdata;

    dcr_sample_if sample_ch ();
    dcr_result_if result_ch ();

    moving_average_dc_remover u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .sample_ch (sample_ch),
        .result_ch (result_ch),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // window predictor state
    sample_t win_ring [DEPTH];
    int      win_idx;
    longint  win_sum;
    bit      win_full;
    bit      simplified;

    // extremes and bit patterns for the warm-up
    int      corner_samples [CORNER_N] = '{0, 32767, -32768, -1, 1, 32767, 32767,
                                           -32768, -32768, 16384, -16384, 21845, -21846,
                                           100, -100, 32767, -32768, 2, -2, 0};

    sample_t pending_samples [$];
    result_t expected_dc [$];
    int      mismatches = 0;

    bit      steady_flow = 1'b0;
    bit      hold_req = 1'b0;
    bit      hold_ack;
    int      hold_left;
    int      send_gap;
    int      send_draw;
    int      rdy_gap;
    int      rdy_draw;
    result_t want_dc;

    task automatic report_mismatch(string msg);
        mismatches++;
        $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    function automatic result_t dc_removed_for(sample_t s);
        longint div_by;
        longint mean;
        win_idx = (win_idx >= DEPTH - 1) ? 0 : win_idx + 1;
        if (win_idx == DEPTH - 1)
            win_full = 1'b1;
        win_sum = win_sum - longint'(win_ring[win_idx]) + longint'(s);
        win_ring[win_idx] = s;
        div_by = (simplified || win_full) ? longint'(DEPTH) : longint'(win_idx + 1);
        // SV division on signed operands truncates toward zero
        mean = win_sum / div_by;
        return result_t'(longint'(s) - mean);
    endfunction

    function automatic sample_t audio_sample(int centre, int spread);
        int v;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: v = int'($urandom_range(0, 65535)) - 32768;
            4, 5, 6, 7: v = centre + int'($urandom_range(0, 2 * spread)) - spread;
            default:    v = $urandom_range(0, 1) ? 32767 : -32768;
        endcase
        if (v > 32767)
            v = 32767;
        if (v < -32768)
            v = -32768;
        return sample_t'(v);
    endfunction

    task automatic queue_audio(int n);
        int centre;
        centre = int'($urandom_range(0, 40000)) - 20000;
        @(negedge clk);
        repeat (n)
            pending_samples.push_back(audio_sample(centre, 2000));
    endtask

    task automatic wait_drained();
        do
            @(negedge clk);
        while (pending_samples.size() != 0 || sample_ch.valid || expected_dc.size() != 0);
    endtask

    task automatic set_simplified_mode(bit mode);
        wait_drained();
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= mode;
        @(posedge clk);
        cfg_we    <= 1'b0;
        simplified = mode;
    endtask

    // request driver: predicts on every accepted sample
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_ch.valid     <= 1'b0;
            sample_ch.sample_in <= '0;
            send_gap            <= 0;
        end
        else if (sample_ch.valid && sample_ch.ready)
        begin
            expected_dc.push_back(dc_removed_for(sample_ch.sample_in));
            send_draw = steady_flow ? 0 : $urandom_range(0, MAX_GAP);
            if (send_draw == 0 && pending_samples.size() != 0)
                sample_ch.sample_in <= pending_samples.pop_front();
            else
            begin
                sample_ch.valid <= 1'b0;
                send_gap        <= send_draw;
            end
        end
        else if (!sample_ch.valid)
        begin
            if (send_gap != 0)
                send_gap <= send_gap - 1;
            else if (pending_samples.size() != 0)
            begin
                sample_ch.sample_in <= pending_samples.pop_front();
                sample_ch.valid     <= 1'b1;
            end
        end
    end

    // result ready with random gaps, plus one long hold on request
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_ch.ready <= 1'b0;
            rdy_gap         <= 0;
            hold_left       <= 0;
            hold_ack        <= 1'b0;
        end
        else if (hold_req != hold_ack)
        begin
            hold_ack        <= hold_req;
            hold_left       <= LONG_HOLD;
            rdy_gap         <= 0;
            result_ch.ready <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left       <= hold_left - 1;
            result_ch.ready <= (hold_left == 1);
        end
        else if (result_ch.valid && result_ch.ready)
        begin
            rdy_draw = steady_flow ? 0 : $urandom_range(0, MAX_GAP);
            rdy_gap         <= rdy_draw;
            result_ch.ready <= (rdy_draw == 0);
        end
        else if (rdy_gap != 0)
        begin
            rdy_gap         <= rdy_gap - 1;
            result_ch.ready <= (rdy_gap == 1);
        end
        else
            result_ch.ready <= 1'b1;
    end

    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && result_ch.valid && result_ch.ready)
        begin
            if (expected_dc.size() == 0)
                report_mismatch($sformatf("result %0d with nothing expected",
                                          result_ch.dc_removed));
            else
            begin
                want_dc = expected_dc.pop_front();
                if (result_ch.dc_removed !== want_dc)
                    report_mismatch($sformatf("dc_removed %0d, expected %0d",
                                              result_ch.dc_removed, want_dc));
            end
        end
    end

    initial
    begin
        #(20_000_000);
        $display("** moving_average_dc_remover: FAILED **");
        $finish;
    end

    initial
    begin
        cfg_we              = 1'b0;
        cfg_wdata           = 1'b0;
        rst_n               = 1'b0;
        foreach (win_ring[i])
            win_ring[i] = '0;
        win_idx    = DEPTH - 1;
        win_sum    = 0;
        win_full   = 1'b0;
        simplified = 1'b0;

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // warm-up, count divisor: extremes and bit patterns
        set_simplified_mode(1'b0);
        @(negedge clk);
        foreach (corner_samples[k])
            pending_samples.push_back(sample_t'(corner_samples[k]));

        // still warming up, but full-window divisor
        set_simplified_mode(1'b1);
        queue_audio(280);

        // back to count divisor mid warm-up, then across the first wrap
        set_simplified_mode(1'b0);
        queue_audio(150);
        wait_drained();
        queue_audio(300);

        // full negative window, then a positive step; long receiver hold meanwhile
        set_simplified_mode(1'b1);
        steady_flow = 1'b1;
        @(negedge clk);
        repeat (520)
            pending_samples.push_back(sample_t'(-32768));
        repeat (10)
            pending_samples.push_back(sample_t'(32767));
        do
            @(negedge clk);
        while (pending_samples.size() > 500);
        hold_req = ~hold_req;
        wait_drained();
        steady_flow = 1'b0;

        set_simplified_mode(1'b0);
        queue_audio(150);
        wait_drained();
        queue_audio(150);

        set_simplified_mode(1'b1);
        queue_audio(370);
        wait_drained();

        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("** moving_average_dc_remover: PASSED **");
        else
            $display("** moving_average_dc_remover: FAILED **");
        $finish;
    end

endmodule
